// File: rtl/core/qr2_pkg.sv
// shared constants, types and helpers for the z[sqrt2] arithmetic unit
package qr2_pkg;

    localparam int WIDTH  = 32;   // arithmetic width, wraps modulo 2^WIDTH
    localparam int FLD_W  = 32;   // width of every numeric port field
    localparam int OP_W   = 3;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_NEG  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_CONJ = 3'd4;
    localparam logic [OP_W-1:0] OP_POW  = 3'd5;
    localparam logic [OP_W-1:0] OP_EQ   = 3'd6;

    typedef logic [WIDTH-1:0] t_word;

    // operand pair fed to the multiplier rank
    typedef enum logic [1:0] {
        MSRC_AB = 2'd0,   // a * b
        MSRC_RS = 2'd1,   // running result * base
        MSRC_SS = 2'd2    // base * base
    } t_msrc;

    typedef struct packed {
        logic  load;      // capture the accepted word
        logic  simple;    // add, sub, neg, conj, eq and the unused code
        logic  pow_init;  // result = 1 (0 for a negative exponent), base = a, check exponent sign
        logic  mul;       // register the four partial products
        t_msrc src;
        logic  wr_r;      // running result <= ring product
        logic  wr_s;      // base <= ring product
        logic  shift;     // exponent >>= 1
        logic  publish;   // move result into output register
    } t_qr2_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            exp_zero;
        logic            exp_lsb;
        logic            err;
    } t_qr2_sts;

    // reduce a port field to the arithmetic width
    function automatic t_word to_word(input logic signed [FLD_W-1:0] x);
        return WIDTH'(x);
    endfunction

    // sign-extend or truncate a result word onto a port field
    function automatic logic signed [FLD_W-1:0] to_field(input t_word x);
        return FLD_W'(signed'(x));
    endfunction

endpackage

// File: rtl/core/qr2_datapath.sv
// operand, power, multiplier and output registers of the z[sqrt2] unit
module qr2_datapath
    import qr2_pkg::*;
(
    input  logic                    i_clk,
    input  t_qr2_cmd                i_cmd,
    output t_qr2_sts                o_sts,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [FLD_W-1:0] i_a_p,
    input  logic signed [FLD_W-1:0] i_a_q,
    input  logic signed [FLD_W-1:0] i_b_p,
    input  logic signed [FLD_W-1:0] i_b_q,
    input  logic signed [FLD_W-1:0] i_exponent,
    output logic signed [FLD_W-1:0] o_res_p,
    output logic signed [FLD_W-1:0] o_res_q,
    output logic                    o_equal,
    output logic                    o_is_integer,
    output logic                    o_error
);

    logic [OP_W-1:0]  r_op;
    t_word            r_ap, r_aq, r_bp, r_bq;
    t_word            r_rp, r_rq;
    t_word            r_sp, r_sq;
    logic [FLD_W-1:0] r_exp;
    logic             r_eq, r_err;
    t_word            r_m0, r_m1, r_m2, r_m3;
    t_word            r_op_p, r_op_q;
    logic             r_o_eq, r_o_int, r_o_err;

    t_word xp, xq, yp, yq;
    t_word sum_p, sum_q;
    t_word simp_p, simp_q;
    logic  simp_eq;

    // multiplier operand select
    always_comb begin
        unique case (i_cmd.src)
            MSRC_AB: begin
                xp = r_ap; xq = r_aq; yp = r_bp; yq = r_bq;
            end
            MSRC_RS: begin
                xp = r_rp; xq = r_rq; yp = r_sp; yq = r_sq;
            end
            MSRC_SS: begin
                xp = r_sp; xq = r_sq; yp = r_sp; yq = r_sq;
            end
            default: begin
                xp = '0; xq = '0; yp = '0; yq = '0;
            end
        endcase
    end

    // (xp + xq*s)(yp + yq*s) = xp*yp + 2*xq*yq + (xp*yq + xq*yp)*s
    assign sum_p = r_m0 + {r_m1[WIDTH-2:0], 1'b0};
    assign sum_q = r_m2 + r_m3;

    always_comb begin
        simp_p  = '0;
        simp_q  = '0;
        simp_eq = 1'b0;
        unique case (r_op)
            OP_ADD:  begin simp_p = r_ap + r_bp; simp_q = r_aq + r_bq; end
            OP_SUB:  begin simp_p = r_ap - r_bp; simp_q = r_aq - r_bq; end
            OP_NEG:  begin simp_p = '0 - r_ap;   simp_q = '0 - r_aq;   end
            OP_CONJ: begin simp_p = r_ap;        simp_q = '0 - r_aq;   end
            OP_EQ:   simp_eq = (r_ap == r_bp) && (r_aq == r_bq);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_ap  <= to_word(i_a_p);
            r_aq  <= to_word(i_a_q);
            r_bp  <= to_word(i_b_p);
            r_bq  <= to_word(i_b_q);
            r_exp <= i_exponent;
            r_rp  <= '0;
            r_rq  <= '0;
            r_eq  <= 1'b0;
            r_err <= 1'b0;
        end
        if (i_cmd.simple) begin
            r_rp <= simp_p;
            r_rq <= simp_q;
            r_eq <= simp_eq;
        end
        if (i_cmd.pow_init) begin
            // a negative exponent leaves a zero result
            r_err <= r_exp[FLD_W-1];
            r_rp  <= r_exp[FLD_W-1] ? t_word'(0) : t_word'(1);
            r_rq  <= '0;
            r_sp  <= r_ap;
            r_sq  <= r_aq;
        end
        if (i_cmd.mul) begin
            r_m0 <= WIDTH'(xp * yp);
            r_m1 <= WIDTH'(xq * yq);
            r_m2 <= WIDTH'(xp * yq);
            r_m3 <= WIDTH'(xq * yp);
        end
        if (i_cmd.wr_r) begin
            r_rp <= sum_p;
            r_rq <= sum_q;
        end
        if (i_cmd.wr_s) begin
            r_sp <= sum_p;
            r_sq <= sum_q;
        end
        if (i_cmd.shift) begin
            r_exp <= r_exp >> 1;
        end
        if (i_cmd.publish) begin
            r_op_p  <= r_rp;
            r_op_q  <= r_rq;
            r_o_eq  <= r_eq;
            r_o_int <= (r_rq == '0);
            r_o_err <= r_err;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];
    assign o_sts.err      = r_err;

    assign o_res_p      = to_field(r_op_p);
    assign o_res_q      = to_field(r_op_q);
    assign o_equal      = r_o_eq;
    assign o_is_integer = r_o_int;
    assign o_error      = r_o_err;

endmodule

// File: rtl/core/qr2_ctrl.sv
// sequencing state machine of the z[sqrt2] unit
module qr2_ctrl
    import qr2_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_qr2_sts i_sts,
    output t_qr2_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POW_CHK,
        S_MUL,
        S_ACC_R,
        S_SQ_MUL,
        S_SQ_ACC,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.src   = MSRC_AB;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.op == OP_MUL) begin
                    n_state = S_MUL;
                end else if (i_sts.op == OP_POW) begin
                    o_cmd.pow_init = 1'b1;
                    n_state        = S_POW_CHK;
                end else begin
                    o_cmd.simple = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_POW_CHK: begin
                priority if (i_sts.err || i_sts.exp_zero) begin
                    n_state = S_FINISH;
                end else if (i_sts.exp_lsb) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQ_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.src = (i_sts.op == OP_MUL) ? MSRC_AB : MSRC_RS;
                n_state   = S_ACC_R;
            end
            S_ACC_R: begin
                o_cmd.wr_r = 1'b1;
                n_state    = (i_sts.op == OP_MUL) ? S_FINISH : S_SQ_MUL;
            end
            S_SQ_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.src = MSRC_SS;
                n_state   = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                o_cmd.wr_s  = 1'b1;
                o_cmd.shift = 1'b1;
                n_state     = S_POW_CHK;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/quadratic_ring_sqrt2_alu.sv
// top level of the z[sqrt2] arithmetic unit: controller, datapath, checks
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_op, i_a_p, i_a_q, i_b_p, i_b_q, i_exponent
//  output    out        o_valid / i_ready    o_res_p, o_res_q, o_equal, o_is_integer, o_error
//
// one word in flight; add, subtract, negate, conjugate, equal and the unused code
//   pass through execute and finish, multiply through execute, product, accumulate, finish
// power checks each exponent bit, multiplies the result by the base for a one bit and
//   squares the base for every bit, on the four shared 32x32 multipliers with one
//   product rank and one add per ring multiply
// a finished result waits in the output register; the next word is accepted
//   while it waits, and only the final publish stalls on a full output register
// i_rst_n is synchronous, active low, and clears the state machine and o_valid
module quadratic_ring_sqrt2_alu
    import qr2_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [OP_W-1:0]         i_op,
    input  logic signed [FLD_W-1:0] i_a_p,
    input  logic signed [FLD_W-1:0] i_a_q,
    input  logic signed [FLD_W-1:0] i_b_p,
    input  logic signed [FLD_W-1:0] i_b_q,
    input  logic signed [FLD_W-1:0] i_exponent,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [FLD_W-1:0] o_res_p,
    output logic signed [FLD_W-1:0] o_res_q,
    output logic                    o_equal,
    output logic                    o_is_integer,
    output logic                    o_error
);

    t_qr2_cmd cmd;   // controller -> datapath
    t_qr2_sts sts;   // datapath -> controller

    // sequencer: accepts a word, steps the exponent loop, publishes the result
    qr2_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // operand registers, multiplier rank, power registers, output register
    qr2_datapath u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_a_p        (i_a_p),
        .i_a_q        (i_a_q),
        .i_b_p        (i_b_p),
        .i_b_q        (i_b_q),
        .i_exponent   (i_exponent),
        .o_res_p      (o_res_p),
        .o_res_q      (o_res_q),
        .o_equal      (o_equal),
        .o_is_integer (o_is_integer),
        .o_error      (o_error)
    );

`ifndef SYNTH
    // a power error always leaves a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> (o_res_p == '0) && (o_res_q == '0) && o_is_integer)
        else $error("error result is not zero");

    // equal and error come from different operations
    a_eq_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_equal && o_error))
        else $error("equal and error both set");

    // a publish only happens into an empty or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_valid || i_ready))
        else $error("result published over a waiting word");

    // the input side is closed while the loop runs
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul |-> !o_ready)
        else $error("input open while multiplying");
`endif

endmodule
